// ===== rtl/core/lcd_line_scroll_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// lcd line scroller assertion macros
// shared property forms for the scroller's concurrent checks
// ----------------------------------------------------------------------------
`ifndef LCD_LINE_SCROLL_CONTROLLER_UNIT_ASSERT_SVH
`define LCD_LINE_SCROLL_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define LCDLS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd scroller check failed");

// next-cycle implication
`define LCDLS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd scroller check failed");

`endif

// ===== rtl/core/lcdls_pkg.sv =====
// ----------------------------------------------------------------------------
// lcd line scroller package
// shared types, codes and constants for the scroller controller and datapath
// ----------------------------------------------------------------------------
package lcdls_pkg;

  localparam int DEF_LINE_COUNT = 4;
  localparam int DEF_LINE_WIDTH = 20;
  localparam int DEF_TEXT_LEN   = 64;

  localparam int CFG_LINES  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_BASE = 3'd4;

  localparam logic [CFG_DATA_W-1:0] START_DELAY_RST = 16'd20480;
  localparam logic [CFG_DATA_W-1:0] CHAR_DELAY_RST  = 16'd8192;

  localparam logic [7:0] ADDR_CMD = 8'h80;
  localparam logic [7:0] SPACE    = 8'h20;
  localparam logic [7:0] CR       = 8'h0d;
  localparam logic [7:0] NUL      = 8'h00;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } item_cmd_t;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_NONE  = 2'd2
  } mode_t;

  typedef struct packed {
    logic latch_item;
    logic mem_write;
    logic set_none;
    logic set_start;
    logic tick_start;
    logic count_inc;
    logic char_read;
    logic tick_advance;
    logic start_init;
    logic emit_addr;
    logic emit_data;
    logic scan_step;
  } lcdls_ctl_t;

  typedef struct packed {
    item_cmd_t item_cmd;
    logic      line_ok;
    logic      pos_ok;
    logic      blocked;
    mode_t     mode;
    logic      count_ge_char;
    logic      out_free;
    logic      char_last;
    logic      t_zero;
    logic      t_space;
    logic      nul_seen;
  } lcdls_stat_t;

  function automatic logic [7:0] line_offset(input logic [1:0] line);
    logic [7:0] off;
    case (line)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      2'd3:    off = 8'h54;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/core/lcdls_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcd line scroller controller
// sequences item dispatch, line writes and the text length scan
// ----------------------------------------------------------------------------
module lcdls_ctrl
  import lcdls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lcdls_stat_t stat,
  output lcdls_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TREAD,
    S_ADDR,
    S_DATA,
    S_SCAN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_item = 1'b1;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        if (stat.line_ok) begin
          case (stat.item_cmd)
            CMD_LOAD:  ctl.mem_write = stat.pos_ok;
            CMD_STOP:  ctl.set_none = 1'b1;
            CMD_START: begin
              ctl.start_init = 1'b1;
              state_next     = S_ADDR;
            end
            CMD_TICK: begin
              if (!stat.blocked) begin
                case (stat.mode)
                  MODE_NONE:  ;
                  MODE_START: ctl.tick_start = 1'b1;
                  MODE_CHAR: begin
                    if (stat.count_ge_char) begin
                      ctl.char_read = 1'b1;
                      state_next    = S_TREAD;
                    end else begin
                      ctl.count_inc = 1'b1;
                    end
                  end
                  default: ctl.set_none = 1'b1;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      S_TREAD: begin
        ctl.tick_advance = 1'b1;
        state_next       = S_ADDR;
      end
      S_ADDR: begin
        if (stat.out_free) begin
          ctl.emit_addr = 1'b1;
          state_next    = S_DATA;
        end
      end
      S_DATA: begin
        if (stat.out_free) begin
          ctl.emit_data = 1'b1;
          if (stat.char_last) begin
            state_next = S_IDLE;
            if (stat.item_cmd == CMD_START) begin
              if (stat.nul_seen || stat.t_zero) begin
                ctl.set_none = 1'b1;
              end else begin
                state_next = S_SCAN;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (stat.t_zero) begin
          ctl.set_none = 1'b1;
          state_next   = S_IDLE;
        end else if (!stat.t_space) begin
          ctl.set_start = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/lcdls_dpath.sv =====
// ----------------------------------------------------------------------------
// lcd line scroller datapath
// delay registers, per-line scroll state, text memory and output register
// ----------------------------------------------------------------------------
module lcdls_dpath
  import lcdls_pkg::*;
#(
  parameter int LINE_COUNT = DEF_LINE_COUNT,
  parameter int LINE_WIDTH = DEF_LINE_WIDTH,
  parameter int TEXT_LEN   = DEF_TEXT_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            cmd,
  input  logic [1:0]            line_sel,
  input  logic [5:0]            char_pos,
  input  logic [7:0]            char_value,
  input  lcdls_ctl_t            ctl,
  output lcdls_stat_t           stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  reg_select,
  output logic [7:0]            lcd_byte,
  output logic                  last_byte
);

  localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int POS_W  = $clog2(TEXT_LEN);
  localparam int IDX_W  = $clog2(TEXT_LEN + LINE_WIDTH + 1);
  localparam int COL_W  = $clog2(LINE_WIDTH);
  localparam int DEPTH  = LINE_COUNT * TEXT_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  // latched item
  item_cmd_t  lat_cmd;
  logic [1:0] lat_line;
  logic [5:0] lat_pos;
  logic [7:0] lat_val;

  logic [CFG_DATA_W-1:0] start_delay [CFG_LINES];
  logic [CFG_DATA_W-1:0] char_delay  [CFG_LINES];

  mode_t             mode  [LINE_COUNT];
  logic [15:0]       count [LINE_COUNT];
  logic [POS_W-1:0]  pos   [LINE_COUNT];

  logic [7:0]        text_mem [DEPTH];
  logic [7:0]        rdata;

  logic [IDX_W-1:0]  idx, idx_next;
  logic [COL_W-1:0]  col;
  logic              done;
  logic              nul_seen;

  logic [LINE_W-1:0] line_idx;
  logic [ADDR_W-1:0] line_base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        t;
  logic              pos_last;
  logic [POS_W-1:0]  new_pos;
  logic              blocked;
  logic [7:0]        data_byte;
  logic              count_ge_start;

  assign line_idx  = lat_line[LINE_W-1:0];
  assign line_base = ADDR_W'(TEXT_LEN) * ADDR_W'(lat_line);
  assign wr_addr   = line_base + ADDR_W'(lat_pos);
  assign rd_addr   = line_base +
                     ((idx_next < IDX_W'(TEXT_LEN)) ? ADDR_W'(idx_next) : '0);

  assign t         = (idx < IDX_W'(TEXT_LEN)) ? rdata : NUL;
  assign pos_last  = (pos[line_idx] == POS_W'(TEXT_LEN - 1));
  assign new_pos   = ((t == NUL) || pos_last) ? '0 : pos[line_idx] + POS_W'(1);
  assign data_byte = (done || (t == NUL) || (t == CR)) ? SPACE : t;
  assign count_ge_start = (count[line_idx] >= start_delay[lat_line]);

  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < CFG_LINES; i++) begin
      if ((i <= int'(lat_line)) && (start_delay[i] == '0)) begin
        blocked = 1'b1;
      end
    end
  end

  always_comb begin
    idx_next = idx;
    if (ctl.start_init) begin
      idx_next = '0;
    end else if (ctl.char_read) begin
      idx_next = IDX_W'(pos[line_idx]);
    end else if (ctl.tick_advance) begin
      idx_next = IDX_W'(new_pos);
    end else if (ctl.emit_data || ctl.scan_step) begin
      idx_next = idx + IDX_W'(1);
    end
  end

  always_comb begin
    stat.item_cmd      = lat_cmd;
    stat.line_ok       = (int'(lat_line) < LINE_COUNT);
    stat.pos_ok        = (int'(lat_pos) < TEXT_LEN);
    stat.blocked       = blocked;
    stat.mode          = mode[line_idx];
    stat.count_ge_char = (count[line_idx] >= char_delay[lat_line]);
    stat.out_free      = !out_valid || out_ready;
    stat.char_last     = (col == COL_W'(LINE_WIDTH - 1));
    stat.t_zero        = (t == NUL);
    stat.t_space       = (t == SPACE);
    stat.nul_seen      = nul_seen;
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      lat_cmd  <= item_cmd_t'(cmd);
      lat_line <= line_sel;
      lat_pos  <= char_pos;
      lat_val  <= char_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_LINES; i++) begin
        start_delay[i] <= START_DELAY_RST;
        char_delay[i]  <= CHAR_DELAY_RST;
      end
    end else if (cfg_write) begin
      if (cfg_index < CFG_CHAR_BASE) begin
        start_delay[2'(cfg_index)] <= cfg_data;
      end else begin
        char_delay[2'(cfg_index - CFG_CHAR_BASE)] <= cfg_data;
      end
    end
  end

  // per-line scroll state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_COUNT; i++) begin
        mode[i]  <= MODE_NONE;
        count[i] <= '0;
        pos[i]   <= '0;
      end
    end else begin
      if (ctl.set_none) begin
        mode[line_idx] <= MODE_NONE;
      end
      if (ctl.set_start) begin
        mode[line_idx] <= MODE_START;
      end
      if (ctl.start_init) begin
        pos[line_idx]   <= '0;
        count[line_idx] <= '0;
      end
      if (ctl.tick_start) begin
        if (count_ge_start) begin
          mode[line_idx]  <= MODE_CHAR;
          pos[line_idx]   <= POS_W'(1);
          count[line_idx] <= 16'd1;
        end else begin
          count[line_idx] <= count[line_idx] + 16'd1;
        end
      end
      if (ctl.count_inc) begin
        count[line_idx] <= count[line_idx] + 16'd1;
      end
      if (ctl.tick_advance) begin
        pos[line_idx]   <= new_pos;
        count[line_idx] <= 16'd1;
        if ((t == NUL) || pos_last) begin
          mode[line_idx] <= MODE_START;
        end
      end
    end
  end

  // text memory, read data follows the walk index
  always_ff @(posedge clk) begin
    if (ctl.mem_write) begin
      text_mem[wr_addr] <= lat_val;
    end
    rdata <= text_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      col      <= '0;
      done     <= 1'b0;
      nul_seen <= 1'b0;
    end else begin
      idx <= idx_next;
      if (ctl.start_init || ctl.tick_advance) begin
        col      <= '0;
        done     <= 1'b0;
        nul_seen <= 1'b0;
      end else if (ctl.emit_data) begin
        col <= col + COL_W'(1);
        if ((t == NUL) || (t == CR)) begin
          done <= 1'b1;
        end
        if (t == NUL) begin
          nul_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_addr || ctl.emit_data) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_addr) begin
      reg_select <= 1'b0;
      lcd_byte   <= ADDR_CMD | line_offset(lat_line);
      last_byte  <= 1'b0;
    end else if (ctl.emit_data) begin
      reg_select <= 1'b1;
      lcd_byte   <= data_byte;
      last_byte  <= stat.char_last;
    end
  end

endmodule

// ===== rtl/core/lcd_line_scroll_controller_unit.sv =====
// ----------------------------------------------------------------------------
// lcd line scroll controller
// Marquee controller for up to four display lines. Load, stop and tick beats
// that cause no line write pass through accept and dispatch. A line write
// sends an address command and LINE_WIDTH data beats from the text memory at
// one beat per cycle while the output does not stall; a tick that scrolls
// first makes one extra memory read of the current character. A start beat
// whose first LINE_WIDTH characters hold no terminator then scans the text
// memory one character a cycle to decide whether the line scrolls. The text
// memory has a single read port. Output stalls hold a line write; a finished
// last beat waits in the output register while the next input beat is taken.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "lcd_line_scroll_controller_unit_assert.svh"

module lcd_line_scroll_controller_unit
  import lcdls_pkg::*;
#(
  parameter int LINE_COUNT = DEF_LINE_COUNT,
  parameter int LINE_WIDTH = DEF_LINE_WIDTH,
  parameter int TEXT_LEN   = DEF_TEXT_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [1:0]            line_sel,
  input  logic [5:0]            char_pos,
  input  logic [7:0]            char_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  reg_select,
  output logic [7:0]            lcd_byte,
  output logic                  last_byte
);

  lcdls_ctl_t  ctl;
  lcdls_stat_t stat;

  lcdls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  lcdls_dpath #(
    .LINE_COUNT (LINE_COUNT),
    .LINE_WIDTH (LINE_WIDTH),
    .TEXT_LEN   (TEXT_LEN)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .line_sel   (line_sel),
    .char_pos   (char_pos),
    .char_value (char_value),
    .ctl        (ctl),
    .stat       (stat),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .reg_select (reg_select),
    .lcd_byte   (lcd_byte),
    .last_byte  (last_byte)
  );

  // an idle controller leaves at most the last beat of a line write pending
  `LCDLS_ASSERT_IMP(a_idle_out_last, clk, rst, in_valid && in_ready, !out_valid || last_byte)
  // a beat taken mid-write means the controller is still busy
  `LCDLS_ASSERT_IMP(a_mid_write_busy, clk, rst, out_valid && out_ready && !last_byte, !in_ready)
  // each accepted beat is dispatched before the next one is taken
  `LCDLS_ASSERT_NXT(a_accept_dispatch, clk, rst, in_valid && in_ready, !in_ready)

endmodule

// ===== dv/tb_lcd_line_scroll_controller_unit.sv =====
// ----------------------------------------------------------------------------
// lcd line scroller testbench
// Fills every line's text store, then runs directed starts, stops and ticks
// and a long scroll over a line with no terminator, then random phases under
// changing delay settings. A predictor in the bench works out each line
// write, and every output beat is checked against it in order. Both sides
// stall at random.
// ----------------------------------------------------------------------------
module tb_lcd_line_scroll_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdls_pkg::*;

  localparam int LINES       = DEF_LINE_COUNT;
  localparam int COLS        = DEF_LINE_WIDTH;
  localparam int TXT         = DEF_TEXT_LEN;
  localparam int SETTLE_CYC  = 80;
  localparam int STALL_LIMIT = 3000;

  typedef enum int {
    REG_START1, REG_START2, REG_START3, REG_START4,
    REG_CHAR1, REG_CHAR2, REG_CHAR3, REG_CHAR4, REG_TOTAL
  } reg_idx_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } lcd_beat_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            cmd;
  logic [1:0]            line_sel;
  logic [5:0]            char_pos;
  logic [7:0]            char_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  reg_select;
  logic [7:0]            lcd_byte;
  logic                  last_byte;

  // predictor state
  logic [15:0] start_ticks [LINES];
  logic [15:0] shift_ticks [LINES];
  mode_t       line_mode [LINES];
  logic [15:0] line_count [LINES];
  int          line_pos [LINES];
  logic [7:0]  text_mem [LINES][TXT];
  logic [15:0] reg_plan [REG_TOTAL];

  lcd_beat_t display_beats [$];
  lcd_beat_t want;
  int        errors;
  int        stall_cycles;
  int        sink_hold;
  int        sink_draw;
  bit        calm;

  lcd_line_scroll_controller_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .line_sel   (line_sel),
    .char_pos   (char_pos),
    .char_value (char_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .lcd_byte   (lcd_byte),
    .last_byte  (last_byte)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] text_byte(input int ln, input int idx);
    if (idx >= TXT) return NUL;
    return text_mem[ln][idx];
  endfunction

  function automatic void queue_line_write(input int ln, input int from);
    lcd_beat_t  b;
    logic [7:0] ch;
    logic [7:0] t;
    logic       stopped;
    stopped = 1'b0;
    b.rs    = 1'b0;
    b.last  = 1'b0;
    case (ln)
      0:       b.data = ADDR_CMD | 8'h00;
      1:       b.data = ADDR_CMD | 8'h40;
      2:       b.data = ADDR_CMD | 8'h14;
      default: b.data = ADDR_CMD | 8'h54;
    endcase
    display_beats.push_back(b);
    for (int c = 0; c < COLS; c++) begin
      ch = SPACE;
      if (!stopped) begin
        t = text_byte(ln, from + c);
        if (t == NUL || t == CR) stopped = 1'b1;
        else ch = t;
      end
      b.rs   = 1'b1;
      b.data = ch;
      b.last = (c == COLS - 1);
      display_beats.push_back(b);
    end
  endfunction

  // text length up to the terminator, trailing spaces dropped
  function automatic int text_span(input int ln);
    int n;
    n = 0;
    for (int i = 0; i < TXT; i++) begin
      if (text_mem[ln][i] == NUL) break;
      if (text_mem[ln][i] != SPACE) n = i + 1;
    end
    return n;
  endfunction

  function automatic void advance_lines(input item_cmd_t c, input int ln, input int p,
                                        input logic [7:0] v);
    logic blocked;
    int   at;
    case (c)
      CMD_LOAD: text_mem[ln][p] = v;
      CMD_STOP: line_mode[ln] = MODE_NONE;
      CMD_START: begin
        queue_line_write(ln, 0);
        line_pos[ln]   = 0;
        line_count[ln] = 16'd0;
        line_mode[ln]  = (text_span(ln) > COLS) ? MODE_START : MODE_NONE;
      end
      default: begin
        blocked = 1'b0;
        for (int i = 0; i <= ln; i++)
          if (start_ticks[i] == 16'd0) blocked = 1'b1;
        if (!blocked && line_mode[ln] != MODE_NONE) begin
          if (line_mode[ln] == MODE_START) begin
            if (line_count[ln] >= start_ticks[ln]) begin
              line_mode[ln]  = MODE_CHAR;
              line_pos[ln]   = 1;
              line_count[ln] = 16'd0;
            end
          end else if (line_count[ln] >= shift_ticks[ln]) begin
            at = line_pos[ln];
            if (text_byte(ln, at) == NUL || at + 1 >= TXT) begin
              line_pos[ln]  = 0;
              line_mode[ln] = MODE_START;
            end else begin
              line_pos[ln] = at + 1;
            end
            queue_line_write(ln, line_pos[ln]);
            line_count[ln] = 16'd0;
          end
          line_count[ln] = line_count[ln] + 16'd1;
        end
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_delay(input bit for_start);
    int sel;
    sel = $urandom_range(0, 11);
    if (for_start) begin
      if (sel == 0) return 16'd0;
      if (sel == 1) return 16'($urandom);
      if (sel < 6) return 16'd1;
      if (sel < 9) return 16'd2;
      return 16'($urandom_range(3, 6));
    end
    if (sel == 0) return 16'($urandom);
    if (sel < 6) return 16'd0;
    if (sel < 9) return 16'd1;
    return 16'($urandom_range(2, 4));
  endfunction

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return NUL;
    if (sel == 1) return CR;
    if (sel < 4) return SPACE;
    if (sel == 4) return 8'hff;
    if (sel < 11) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_v);
    errors++;
    if (errors <= 40)
      $display("%0t ns mismatch %s: got %h want %h", $time, what, got, exp_v);
  endtask

  task automatic send_item(input item_cmd_t c, input logic [1:0] ln, input logic [5:0] p,
                           input logic [7:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    line_sel   <= ln;
    char_pos   <= p;
    char_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_lines(c, int'(ln), int'(p), v);
  endtask

  task automatic send_tick(input logic [1:0] ln);
    send_item(CMD_TICK, ln, 6'($urandom), 8'($urandom));
  endtask

  task automatic send_start(input logic [1:0] ln);
    send_item(CMD_START, ln, 6'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (display_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apply_reg_plan();
    for (int i = 0; i < REG_TOTAL; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= reg_plan[i];
      @(posedge clk);
      if (i < REG_CHAR1) start_ticks[i] = reg_plan[i];
      else shift_ticks[i - REG_CHAR1] = reg_plan[i];
    end
    cfg_write <= 1'b0;
  endtask

  task automatic plan_all(input logic [15:0] start_v, input logic [15:0] shift_v);
    for (int i = 0; i < REG_TOTAL; i++)
      reg_plan[i] = (i < REG_CHAR1) ? start_v : shift_v;
  endtask

  // long, exactly 20, 21 with trailing spaces, no terminator with a cr inside
  task automatic test_text_load();
    logic [7:0] b;
    for (int ln = 0; ln < LINES; ln++) begin
      for (int i = 0; i < TXT; i++) begin
        case (ln)
          0: b = (i < 40) ? ((i % 6 == 5) ? SPACE : 8'(8'h41 + i % 26)) :
                 (i == 40) ? NUL : 8'($urandom_range(1, 255));
          1: b = (i < 20) ? 8'(8'h61 + i) : (i < 28) ? SPACE :
                 (i == 28) ? NUL : 8'($urandom_range(0, 255));
          2: b = (i < 21) ? 8'(8'h30 + i % 10) : (i < 27) ? SPACE :
                 (i == 27) ? NUL : 8'($urandom_range(0, 255));
          default: b = (i == 10) ? CR : (i == 33) ? 8'hff : 8'(8'h21 + i);
        endcase
        send_item(CMD_LOAD, ln[1:0], i[5:0], b);
      end
    end
  endtask

  task automatic test_start_trim();
    send_tick(2'd1);
    for (int ln = 0; ln < LINES; ln++) send_start(ln[1:0]);
    send_tick(2'd0);
    send_item(CMD_LOAD, 2'd1, 6'd0, NUL);
    send_start(2'd1);
    send_item(CMD_LOAD, 2'd1, 6'd0, 8'h61);
  endtask

  task automatic test_stop();
    send_item(CMD_STOP, 2'd2, 6'd63, 8'hff);
    send_tick(2'd2);
  endtask

  task automatic test_scroll_steps();
    settle();
    plan_all(16'd1, 16'd0);
    apply_reg_plan();
    send_start(2'd0);
    repeat (4) send_tick(2'd0);
  endtask

  task automatic test_start_delay_block();
    settle();
    reg_plan[REG_START3] = 16'd0;
    apply_reg_plan();
    send_tick(2'd3);
    send_tick(2'd3);
    send_tick(2'd0);
  endtask

  // walks the unterminated line to the end of its store and back to the start
  task automatic test_store_end();
    settle();
    plan_all(16'd1, 16'd0);
    apply_reg_plan();
    send_start(2'd3);
    repeat (70) send_tick(2'd3);
  endtask

  task automatic test_random_traffic();
    logic [1:0] focus;
    logic [1:0] ln;
    int         roll;
    for (int k = 0; k < REG_TOTAL; k++) begin
      settle();
      calm = (k % 3 == 2);
      for (int r = 0; r < REG_TOTAL; r++) reg_plan[r] = pick_delay(r < REG_CHAR1);
      reg_plan[k] = 16'hffff;
      apply_reg_plan();
      focus = 2'($urandom_range(0, 3));
      send_start(focus);
      repeat (4) begin
        roll = $urandom_range(0, 99);
        ln   = 2'($urandom_range(0, 3));
        if (roll < 8)
          send_item(CMD_LOAD, ln, 6'($urandom_range(0, 63)), pick_char());
        else if (roll < 13)
          send_start(roll[0] ? focus : ln);
        else if (roll < 16)
          send_item(CMD_STOP, ln, 6'($urandom), 8'($urandom));
        else
          send_tick((roll % 4 == 0) ? ln : focus);
      end
    end
    calm = 1'b0;
  endtask

  // output side: random stalls per beat
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_ready && out_valid) begin
      sink_draw = calm ? 0 : $urandom_range(0, 14);
      if (sink_draw != 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_draw - 1;
      end
    end else if (!out_ready) begin
      if (sink_hold != 0) sink_hold <= sink_hold - 1;
      else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (display_beats.size() == 0) begin
        report_mismatch("beat with nothing pending", lcd_byte, 8'h00);
      end else begin
        want = display_beats.pop_front();
        if (reg_select !== want.rs) report_mismatch("reg_select", 8'(reg_select), 8'(want.rs));
        if (lcd_byte !== want.data) report_mismatch("lcd_byte", lcd_byte, want.data);
        if (last_byte !== want.last) report_mismatch("last_byte", 8'(last_byte), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_lcd_line_scroll_controller_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    cmd        = CMD_TICK;
    line_sel   = 2'd0;
    char_pos   = 6'd0;
    char_value = 8'd0;
    out_ready  = 1'b0;
    errors     = 0;
    calm       = 1'b0;
    for (int i = 0; i < LINES; i++) begin
      start_ticks[i] = START_DELAY_RST;
      shift_ticks[i] = CHAR_DELAY_RST;
      line_mode[i]   = MODE_NONE;
      line_count[i]  = 16'd0;
      line_pos[i]    = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_text_load();
    test_start_trim();
    test_stop();
    test_scroll_steps();
    test_start_delay_block();
    test_store_end();
    test_random_traffic();
    settle();
    if (errors == 0 && display_beats.size() == 0) begin
      $display("tb_lcd_line_scroll_controller_unit: clean");
    end else begin
      $display("tb_lcd_line_scroll_controller_unit: errors");
    end
    $finish;
  end

endmodule
